FILE: rtl/lfu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_pkg: shared constants for the LFU cache
// Widths, command codes and the miss value used by the cache and its checker.
// ----------------------------------------------------------------------------
package lfu_pkg;

    localparam int LFU_ENTRIES = 16;
    localparam int CAP_W       = 5;
    localparam int DATA_W      = 32;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    localparam logic [DATA_W-1:0] MISS_VALUE = {DATA_W{1'b1}};
    localparam logic [DATA_W-1:0] COUNT_ONE  = DATA_W'(1);

endpackage

FILE: rtl/lfu_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module lfu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rd_data_reg <= mem_reg[raddr];
    end

    assign rdata = rd_data_reg;

endmodule

FILE: rtl/lfu_cache.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_cache: key-value cache, least-frequently-used replacement
// Lookup and insert with LRU tie break among equal use counts. Entries live in
// one RAM; a sequencer scans it (if capacity > 0) and sweeps it again on a put or get hit.
// ----------------------------------------------------------------------------
//  channel   signals                          direction  content
//  in        in_valid / in_ready              input      cmd, key, value_in
//  out       out_valid / out_ready            output     hit, read_value
//  cfg       cfg_valid / cfg_ready            input      cfg_data (capacity)
//
//  The single RAM read port gives one entry per cycle in the scan pass
//  (key match, victim, free slot) and one per cycle in the rank update pass.
//  in_ready is high only between items; one finished result may wait in the
//  output register while the next item is worked on.
//  Reset clears all valid bits, fill count and capacity; no clearing pass.
// ----------------------------------------------------------------------------
module lfu_cache
    import lfu_pkg::*;
#(
    parameter int ENTRIES = LFU_ENTRIES
) (
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     cmd,
    input  logic signed [DATA_W-1:0] key,
    input  logic signed [DATA_W-1:0] value_in,

    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     hit,
    output logic signed [DATA_W-1:0] read_value,

    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CAP_W-1:0]         cfg_data
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_UPD    = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    typedef struct packed {
        logic [DATA_W-1:0] key;
        logic [DATA_W-1:0] value;
        logic [DATA_W-1:0] count;
        logic [IDX_W-1:0]  rank;
    } entry_t;

    localparam int ENT_W = $bits(entry_t);

    // control
    logic [2:0]         state_reg,    state_next;
    logic [CNT_W-1:0]   cnt_reg,      cnt_next;
    logic [ENTRIES-1:0] valid_reg,    valid_next;
    logic [CNT_W-1:0]   fill_reg,     fill_next;
    logic [CAP_W-1:0]   capacity_reg;
    logic               out_valid_reg, out_valid_next;

    // item and scan results
    logic               cmd_reg,      cmd_next;
    logic [DATA_W-1:0]  key_reg,      key_next;
    logic [DATA_W-1:0]  vin_reg,      vin_next;
    logic               found_reg,    found_next;
    logic [IDX_W-1:0]   slot_reg,     slot_next;
    logic [DATA_W-1:0]  hval_reg,     hval_next;
    logic [IDX_W-1:0]   hrank_reg,    hrank_next;
    logic               vfound_reg,   vfound_next;
    logic [IDX_W-1:0]   vic_reg,      vic_next;
    logic [DATA_W-1:0]  vcnt_reg,     vcnt_next;
    logic [IDX_W-1:0]   vrank_reg,    vrank_next;
    logic               ffound_reg,   ffound_next;
    logic [IDX_W-1:0]   free_reg,     free_next;
    logic [IDX_W-1:0]   tgt_reg,      tgt_next;
    logic [IDX_W-1:0]   refr_reg,     refr_next;
    logic               ins_reg,      ins_next;
    logic               evict_reg,    evict_next;
    logic               res_hit_reg,  res_hit_next;
    logic [DATA_W-1:0]  res_val_reg,  res_val_next;
    logic               out_hit_reg,  out_hit_next;
    logic [DATA_W-1:0]  out_val_reg,  out_val_next;

    logic [CMP_W-1:0]   cap_ext;
    logic [CNT_W-1:0]   cap_eff;
    logic [CNT_W-1:0]   ev_full;
    logic [IDX_W-1:0]   ev_idx;
    logic               ev_on;
    logic               cnt_end;
    logic               ev_valid;
    logic [ENT_W-1:0]   ram_rdata;
    entry_t             rd_ent;
    entry_t             wr_ent;
    logic               ram_we;
    logic               tgt_hit;
    logic               do_evict;
    logic [IDX_W-1:0]   ins_slot;

    assign cap_ext = CMP_W'(capacity_reg);
    assign cap_eff = (cap_ext > CMP_W'(ENTRIES)) ? CNT_W'(ENTRIES) : CNT_W'(cap_ext);

    // the entry evaluated this cycle is the one whose read was issued last cycle
    assign ev_full  = cnt_reg - CNT_W'(1);
    assign ev_idx   = ev_full[IDX_W-1:0];
    assign ev_on    = (cnt_reg != '0);
    assign cnt_end  = (cnt_reg == CNT_W'(ENTRIES));
    assign ev_valid = valid_reg[ev_idx];
    assign rd_ent   = entry_t'(ram_rdata);
    assign tgt_hit  = (ev_idx == tgt_reg);

    assign do_evict = (fill_reg >= cap_eff);
    assign ins_slot = !do_evict ? free_reg :
                      ((ffound_reg && (free_reg < vic_reg)) ? free_reg : vic_reg);

    // rank update pass
    always_comb
    begin
        wr_ent = rd_ent;
        if (tgt_hit)
        begin
            wr_ent.rank = '0;
            if (ins_reg)
            begin
                wr_ent.key   = key_reg;
                wr_ent.value = vin_reg;
                wr_ent.count = COUNT_ONE;
            end
            else
            begin
                if (cmd_reg == CMD_PUT)
                begin
                    wr_ent.value = vin_reg;
                end
                if (rd_ent.count != MISS_VALUE)
                begin
                    wr_ent.count = rd_ent.count + COUNT_ONE;
                end
            end
        end
        else if (ins_reg)
        begin
            // drop one rank behind the evicted entry, then age by one for the insert
            if (evict_reg && (rd_ent.rank > refr_reg))
            begin
                wr_ent.rank = rd_ent.rank;
            end
            else
            begin
                wr_ent.rank = rd_ent.rank + IDX_W'(1);
            end
        end
        else if (rd_ent.rank < refr_reg)
        begin
            wr_ent.rank = rd_ent.rank + IDX_W'(1);
        end
    end

    assign ram_we = (state_reg == S_UPD) && ev_on && (tgt_hit || ev_valid);

    lfu_ram #(
        .WIDTH (ENT_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ev_idx),
        .wdata (wr_ent),
        .raddr (cnt_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        valid_next     = valid_reg;
        fill_next      = fill_reg;
        out_valid_next = out_valid_reg;
        cmd_next       = cmd_reg;
        key_next       = key_reg;
        vin_next       = vin_reg;
        found_next     = found_reg;
        slot_next      = slot_reg;
        hval_next      = hval_reg;
        hrank_next     = hrank_reg;
        vfound_next    = vfound_reg;
        vic_next       = vic_reg;
        vcnt_next      = vcnt_reg;
        vrank_next     = vrank_reg;
        ffound_next    = ffound_reg;
        free_next      = free_reg;
        tgt_next       = tgt_reg;
        refr_next      = refr_reg;
        ins_next       = ins_reg;
        evict_next     = evict_reg;
        res_hit_next   = res_hit_reg;
        res_val_next   = res_val_reg;
        out_hit_next   = out_hit_reg;
        out_val_next   = out_val_reg;

        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next     = cmd;
                    key_next     = key;
                    vin_next     = value_in;
                    found_next   = 1'b0;
                    vfound_next  = 1'b0;
                    ffound_next  = 1'b0;
                    cnt_next     = '0;
                    res_hit_next = 1'b0;
                    res_val_next = MISS_VALUE;
                    state_next   = (cap_eff == '0) ? S_DONE : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (ev_on)
                begin
                    if (ev_valid && (rd_ent.key == key_reg) && !found_reg)
                    begin
                        found_next = 1'b1;
                        slot_next  = ev_idx;
                        hval_next  = rd_ent.value;
                        hrank_next = rd_ent.rank;
                    end
                    if (ev_valid && (!vfound_reg || (rd_ent.count < vcnt_reg) ||
                        ((rd_ent.count == vcnt_reg) && (rd_ent.rank > vrank_reg))))
                    begin
                        vfound_next = 1'b1;
                        vic_next    = ev_idx;
                        vcnt_next   = rd_ent.count;
                        vrank_next  = rd_ent.rank;
                    end
                    if (!ev_valid && !ffound_reg)
                    begin
                        ffound_next = 1'b1;
                        free_next   = ev_idx;
                    end
                end
                if (cnt_end)
                begin
                    cnt_next   = '0;
                    state_next = S_DECIDE;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            S_DECIDE:
            begin
                if (found_reg)
                begin
                    tgt_next     = slot_reg;
                    refr_next    = hrank_reg;
                    ins_next     = 1'b0;
                    evict_next   = 1'b0;
                    res_hit_next = 1'b1;
                    res_val_next = (cmd_reg == CMD_GET) ? hval_reg : MISS_VALUE;
                    state_next   = S_UPD;
                end
                else if (cmd_reg == CMD_GET)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    tgt_next   = ins_slot;
                    refr_next  = vrank_reg;
                    ins_next   = 1'b1;
                    evict_next = do_evict;
                    if (do_evict)
                    begin
                        valid_next[vic_reg] = 1'b0;
                    end
                    else
                    begin
                        fill_next = fill_reg + CNT_W'(1);
                    end
                    valid_next[ins_slot] = 1'b1;
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                if (cnt_end)
                begin
                    cnt_next   = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_hit_next   = res_hit_reg;
                    out_val_next   = res_val_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            valid_reg     <= '0;
            fill_reg      <= '0;
            capacity_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            valid_reg     <= valid_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                capacity_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        key_reg     <= key_next;
        vin_reg     <= vin_next;
        found_reg   <= found_next;
        slot_reg    <= slot_next;
        hval_reg    <= hval_next;
        hrank_reg   <= hrank_next;
        vfound_reg  <= vfound_next;
        vic_reg     <= vic_next;
        vcnt_reg    <= vcnt_next;
        vrank_reg   <= vrank_next;
        ffound_reg  <= ffound_next;
        free_reg    <= free_next;
        tgt_reg     <= tgt_next;
        refr_reg    <= refr_next;
        ins_reg     <= ins_next;
        evict_reg   <= evict_next;
        res_hit_reg <= res_hit_next;
        res_val_reg <= res_val_next;
        out_hit_reg <= out_hit_next;
        out_val_reg <= out_val_next;
    end

    assign in_ready   = (state_reg == S_IDLE);
    assign cfg_ready  = 1'b1;
    assign out_valid  = out_valid_reg;
    assign hit        = out_hit_reg;
    assign read_value = out_val_reg;

endmodule

FILE: rtl/lfu_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_chk: port-level checker for the LFU cache
// Tracks items in flight and checks in-flight depth, output hold and miss values.
// ----------------------------------------------------------------------------
module lfu_chk
    import lfu_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_ready,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic                     hit,
    input logic signed [DATA_W-1:0] read_value
);

    logic       in_acc;
    logic       out_acc;
    logic [2:0] pend_reg;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    // items accepted but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else if (in_acc && !out_acc)
        begin
            pend_reg <= pend_reg + 3'd1;
        end
        else if (out_acc && !in_acc && (pend_reg != '0))
        begin
            pend_reg <= pend_reg - 3'd1;
        end
    end

    a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pend_reg != '0))
        else $error("result with no item in flight");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= 3'd2)
        else $error("more than two items in flight");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !in_ready)
        else $error("ready right after an item was taken");

    a_miss_value: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !hit) |-> (read_value == MISS_VALUE))
        else $error("miss without all-ones value");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(hit) && $stable(read_value)))
        else $error("stalled result changed");

endmodule

bind lfu_cache lfu_chk u_lfu_chk (.*);
